/* hw/rtl/stsr_pkg.sv */
`timescale 1ns / 1ps

package stsr_pkg;

  // Fixed field widths of the block's ports.
  localparam int WORD_W      = 32;
  localparam int SIZE_W      = 7;
  localparam int IDX_W       = 6;
  localparam int POS_W       = 6;
  localparam int STATUS_W    = 3;
  localparam int CMD_W       = 2;
  localparam int AXIS_W      = 2;
  localparam int DIM_COUNT_W = 3;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 7;
  localparam int NUM_DIMS    = 4;

  // Defaults for the top-level parameters.
  localparam int DEF_ELEMENT_CAPACITY = 64;
  localparam int DEF_MAX_DIMS         = 4;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_DIM_COUNT = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SIZE_DIM0 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SIZE_DIM1 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SIZE_DIM2 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SIZE_DIM3 = 3'd4;

  // Reset shape: one dimension of 64 elements.
  localparam logic [DIM_COUNT_W-1:0] RST_DIM_COUNT = 3'd1;
  localparam logic [SIZE_W-1:0]      RST_SIZE_DIM0 = 7'd64;
  localparam logic [SIZE_W-1:0]      RST_SIZE_REST = 7'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_SLICE  = 2'd2,
    CMD_COLUMN = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_INDEX     = 3'd1,
    ST_AXIS      = 3'd2,
    ST_POSITION  = 3'd3,
    ST_COLUMN_2D = 3'd4,
    ST_SHAPE     = 3'd5
  } status_t;

  typedef logic [SIZE_W-1:0] size_t;

  // Current shape as seen by the command logic.
  typedef struct packed {
    logic                   ok;
    logic [DIM_COUNT_W-1:0] dim_count;
    size_t [NUM_DIMS-1:0]   size;
    size_t [NUM_DIMS-1:0]   stride;
    size_t                  total;
  } shape_t;

  // Result fields that travel alongside a memory access.
  typedef struct packed {
    logic             use_mem;
    status_t          status;
    logic             last;
    logic [POS_W-1:0] position;
  } meta_t;

  // One finished result transaction.
  typedef struct packed {
    logic [WORD_W-1:0] value;
    status_t           status;
    logic              last;
    logic [POS_W-1:0]  position;
  } result_t;

endpackage

/* hw/rtl/strided_tensor_store.sv */
`timescale 1ns / 1ps

// Row-major tensor store of up to ELEMENT_CAPACITY 32-bit words with one to
// MAX_DIMS dimensions. Every input transaction gives at least one result
// transaction; status is nonzero on any error and last marks the final
// result. A write or read makes one access of the memory port; its result
// fields are registered beside the read data and then pass through the
// result queue. A slice or column is set up when accepted and then streams
// one element per cycle through the same port while the result queue has
// room; the next input is taken when the stream has issued its last read.
// After reset and after each write of a known configuration register, a
// stride sequencer walks the dimensions, one per cycle, and holds the input
// channel stalled. The store reads as zero after reset; per-word written
// flags stand in for a clearing pass. A two-entry result queue lets the
// block keep working while the output side stalls.
module strided_tensor_store #(
  parameter int ELEMENT_CAPACITY = stsr_pkg::DEF_ELEMENT_CAPACITY,
  parameter int MAX_DIMS         = stsr_pkg::DEF_MAX_DIMS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [stsr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [stsr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [stsr_pkg::CMD_W-1:0]       command,
  input  logic [stsr_pkg::IDX_W-1:0]       index_dim0,
  input  logic [stsr_pkg::IDX_W-1:0]       index_dim1,
  input  logic [stsr_pkg::IDX_W-1:0]       index_dim2,
  input  logic [stsr_pkg::IDX_W-1:0]       index_dim3,
  input  logic [stsr_pkg::WORD_W-1:0]      write_value,
  input  logic [stsr_pkg::AXIS_W-1:0]      slice_axis,
  input  logic [stsr_pkg::IDX_W-1:0]       slice_position,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [stsr_pkg::WORD_W-1:0]      read_value,
  output logic [stsr_pkg::STATUS_W-1:0]    status,
  output logic                             last,
  output logic [stsr_pkg::POS_W-1:0]       position
);

  import stsr_pkg::*;

  localparam int ADDR_W = $clog2(ELEMENT_CAPACITY);

  shape_t             shape;
  logic               shape_busy;
  logic               can_issue;
  logic               mem_en;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_addr;
  logic [WORD_W-1:0]  mem_wdata;
  logic [WORD_W-1:0]  mem_rdata;
  meta_t              meta;
  logic               meta_valid;
  result_t            push_data;
  result_t            out_data;
  logic [1:0]         level;
  logic               pop;
  logic [2:0]         occ;

  // Registers are taken in any cycle.
  assign cfg_ready = 1'b1;

  stsr_shape #(
    .ELEMENT_CAPACITY (ELEMENT_CAPACITY),
    .MAX_DIMS         (MAX_DIMS)
  ) u_shape (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .shape     (shape),
    .busy      (shape_busy)
  );

  // Issue only when the queue has room for every result in flight.
  assign occ       = {1'b0, level} + {2'b00, meta_valid};
  assign can_issue = (occ < 3'd2) || (pop && (occ == 3'd2));

  stsr_ctrl #(
    .ELEMENT_CAPACITY (ELEMENT_CAPACITY)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .index_dim0     (index_dim0),
    .index_dim1     (index_dim1),
    .index_dim2     (index_dim2),
    .index_dim3     (index_dim3),
    .write_value    (write_value),
    .slice_axis     (slice_axis),
    .slice_position (slice_position),
    .shape          (shape),
    .shape_busy     (shape_busy),
    .can_issue      (can_issue),
    .mem_en         (mem_en),
    .mem_we         (mem_we),
    .mem_addr       (mem_addr),
    .mem_wdata      (mem_wdata),
    .meta           (meta),
    .meta_valid     (meta_valid)
  );

  stsr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ELEMENT_CAPACITY)
  ) u_store (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Join the read data with its result fields; unwritten words read as zero.
  always_comb begin
    push_data.value    = meta.use_mem ? mem_rdata : '0;
    push_data.status   = meta.status;
    push_data.last     = meta.last;
    push_data.position = meta.position;
  end

  stsr_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (meta_valid),
    .push_data (push_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .level     (level),
    .pop       (pop)
  );

  assign read_value = out_data.value;
  assign status     = out_data.status;
  assign last       = out_data.last;
  assign position   = out_data.position;

endmodule

/* hw/rtl/stsr_ram.sv */
`timescale 1ns / 1ps

module stsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

/* hw/rtl/stsr_shape.sv */
`timescale 1ns / 1ps

module stsr_shape #(
  parameter int ELEMENT_CAPACITY = 64,
  parameter int MAX_DIMS         = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic [stsr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [stsr_pkg::CFG_DATA_W-1:0]    cfg_data,
  output stsr_pkg::shape_t                   shape,
  output logic                               busy
);

  import stsr_pkg::*;

  // The accumulator saturates just above capacity.
  localparam int ACC_W  = $clog2(ELEMENT_CAPACITY + 2);
  localparam int PROD_W = ACC_W + SIZE_W;
  localparam logic [ACC_W-1:0]       ACC_SAT   = ACC_W'(ELEMENT_CAPACITY + 1);
  localparam logic [PROD_W-1:0]      PROD_CAP  = PROD_W'(ELEMENT_CAPACITY);
  localparam logic [ACC_W-1:0]       ACC_CAP   = ACC_W'(ELEMENT_CAPACITY);
  localparam logic [DIM_COUNT_W-1:0] MAX_DIMS_C = DIM_COUNT_W'(MAX_DIMS);
  localparam logic [1:0]             LAST_STEP = 2'(NUM_DIMS - 1);

  logic [DIM_COUNT_W-1:0] dim_count;
  size_t [NUM_DIMS-1:0]   size;
  size_t [NUM_DIMS-1:0]   stride;
  logic [1:0]             step;
  logic [ACC_W-1:0]       acc;
  logic                   zero_seen;
  logic                   known_reg;
  logic                   step_used;
  logic [PROD_W-1:0]      prod;

  assign known_reg = (cfg_index == REG_DIM_COUNT) || (cfg_index == REG_SIZE_DIM0) ||
                     (cfg_index == REG_SIZE_DIM1) || (cfg_index == REG_SIZE_DIM2) ||
                     (cfg_index == REG_SIZE_DIM3);

  // A dimension takes part when it is inside both the count and the build limit.
  assign step_used = ({1'b0, step} < dim_count) &&
                     ({1'b0, step} < MAX_DIMS_C);
  assign prod      = PROD_W'(acc) * PROD_W'(size[step]);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      dim_count <= RST_DIM_COUNT;
      size[0]   <= RST_SIZE_DIM0;
      size[1]   <= RST_SIZE_REST;
      size[2]   <= RST_SIZE_REST;
      size[3]   <= RST_SIZE_REST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DIM_COUNT: dim_count <= cfg_data[DIM_COUNT_W-1:0];
        REG_SIZE_DIM0: size[0] <= cfg_data;
        REG_SIZE_DIM1: size[1] <= cfg_data;
        REG_SIZE_DIM2: size[2] <= cfg_data;
        REG_SIZE_DIM3: size[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stride derivation: walks from the innermost dimension outward, one per
  // cycle, building the suffix product and the element count.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b1;
      step      <= LAST_STEP;
      acc       <= ACC_W'(1);
      zero_seen <= 1'b0;
    end else if (cfg_valid && known_reg) begin
      busy      <= 1'b1;
      step      <= LAST_STEP;
      acc       <= ACC_W'(1);
      zero_seen <= 1'b0;
    end else if (busy) begin
      if (step_used) begin
        if (size[step] == '0) begin
          zero_seen <= 1'b1;
        end
        acc <= (prod > PROD_CAP) ? ACC_SAT : prod[ACC_W-1:0];
      end
      if (step == 2'd0) begin
        busy <= 1'b0;
      end else begin
        step <= step - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      stride[step] <= step_used ? SIZE_W'(acc) : '0;
    end
  end

  always_comb begin
    shape.ok        = (dim_count != '0) && (dim_count <= MAX_DIMS_C) &&
                      !zero_seen && (acc <= ACC_CAP);
    shape.dim_count = dim_count;
    shape.size      = size;
    shape.stride    = stride;
    shape.total     = SIZE_W'(acc);
  end

endmodule

/* hw/rtl/stsr_ctrl.sv */
`timescale 1ns / 1ps

module stsr_ctrl #(
  parameter int ELEMENT_CAPACITY = 64
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [stsr_pkg::CMD_W-1:0]             command,
  input  logic [stsr_pkg::IDX_W-1:0]             index_dim0,
  input  logic [stsr_pkg::IDX_W-1:0]             index_dim1,
  input  logic [stsr_pkg::IDX_W-1:0]             index_dim2,
  input  logic [stsr_pkg::IDX_W-1:0]             index_dim3,
  input  logic [stsr_pkg::WORD_W-1:0]            write_value,
  input  logic [stsr_pkg::AXIS_W-1:0]            slice_axis,
  input  logic [stsr_pkg::IDX_W-1:0]             slice_position,
  input  stsr_pkg::shape_t                       shape,
  input  logic                                   shape_busy,
  input  logic                                   can_issue,
  output logic                                   mem_en,
  output logic                                   mem_we,
  output logic [$clog2(ELEMENT_CAPACITY)-1:0]    mem_addr,
  output logic [stsr_pkg::WORD_W-1:0]            mem_wdata,
  output stsr_pkg::meta_t                        meta,
  output logic                                   meta_valid
);

  import stsr_pkg::*;

  localparam int ADDR_W = $clog2(ELEMENT_CAPACITY);
  localparam int OFF_W  = IDX_W + SIZE_W + 2;
  localparam int PROD_W = 2 * SIZE_W;
  localparam logic [OFF_W-1:0] OFF_CAP = OFF_W'(ELEMENT_CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_SLICE = 2'b10
  } state_t;

  state_t                    state;
  logic [ELEMENT_CAPACITY-1:0] written;

  // Slice walk registers.
  size_t                     base;
  size_t                     inner;
  size_t                     st;
  size_t                     block;
  logic [POS_W-1:0]          count;

  logic                      accept;
  logic [IDX_W-1:0]          idx [NUM_DIMS];
  logic                      idx_err;
  logic [OFF_W-1:0]          off_sum;
  logic [AXIS_W-1:0]         axis_sel;
  size_t                     ax_size;
  size_t                     ax_st;
  logic [PROD_W-1:0]         block_full;
  logic [PROD_W-1:0]         base_full;
  logic [SIZE_W:0]           inner_inc;
  logic [SIZE_W:0]           run_next;
  logic [SIZE_W:0]           walk_addr;
  logic                      run_end;
  logic                      slice_last;
  logic                      start_slice;
  logic                      iss;
  logic                      iss_en;
  logic                      iss_we;
  logic [ADDR_W-1:0]         iss_addr;
  meta_t                     iss_meta;

  assign in_stall = shape_busy || !can_issue || (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  assign idx[0] = index_dim0;
  assign idx[1] = index_dim1;
  assign idx[2] = index_dim2;
  assign idx[3] = index_dim3;

  // Index range check and flat offset; unused dimensions have stride zero.
  always_comb begin
    idx_err = 1'b0;
    off_sum = '0;
    for (int d = 0; d < NUM_DIMS; d++) begin
      if ((DIM_COUNT_W'(d) < shape.dim_count) && ({1'b0, idx[d]} >= shape.size[d])) begin
        idx_err = 1'b1;
      end
      off_sum = off_sum + OFF_W'(idx[d]) * OFF_W'(shape.stride[d]);
    end
  end

  // Axis geometry for a slice or column.
  assign axis_sel   = (cmd_t'(command) == CMD_COLUMN) ? AXIS_W'(1) : slice_axis;
  assign ax_size    = shape.size[axis_sel];
  assign ax_st      = shape.stride[axis_sel];
  assign block_full = PROD_W'(ax_st) * PROD_W'(ax_size);
  assign base_full  = PROD_W'(slice_position) * PROD_W'(ax_st);

  // Walk position: each run of stride elements sits one block after the last.
  assign inner_inc  = {1'b0, inner} + (SIZE_W + 1)'(1);
  assign run_next   = {1'b0, base} + {1'b0, block};
  assign walk_addr  = {1'b0, base} + {1'b0, inner};
  assign run_end    = (inner_inc == {1'b0, st});
  assign slice_last = run_end && (run_next >= {1'b0, shape.total});

  // Decode of the accepted command, or the next element of a slice.
  always_comb begin
    iss          = 1'b0;
    iss_en       = 1'b0;
    iss_we       = 1'b0;
    iss_addr     = off_sum[ADDR_W-1:0];
    start_slice  = 1'b0;
    iss_meta     = '{use_mem: 1'b0, status: ST_OK, last: 1'b1, position: '0};
    if (state == S_SLICE) begin
      if (can_issue) begin
        iss               = 1'b1;
        iss_en            = 1'b1;
        iss_addr          = walk_addr[ADDR_W-1:0];
        iss_meta.use_mem  = written[walk_addr[ADDR_W-1:0]];
        iss_meta.last     = slice_last;
        iss_meta.position = count;
      end
    end else if (accept) begin
      iss = 1'b1;
      if (!shape.ok) begin
        iss_meta.status = ST_SHAPE;
      end else begin
        case (cmd_t'(command))
          CMD_WRITE, CMD_READ: begin
            if (idx_err || (off_sum >= OFF_CAP)) begin
              iss_meta.status = ST_INDEX;
            end else if (cmd_t'(command) == CMD_WRITE) begin
              iss_en = 1'b1;
              iss_we = 1'b1;
            end else begin
              iss_en           = 1'b1;
              iss_meta.use_mem = written[off_sum[ADDR_W-1:0]];
            end
          end
          CMD_COLUMN: begin
            if (shape.dim_count < DIM_COUNT_W'(2)) begin
              iss_meta.status = ST_COLUMN_2D;
            end else if ({1'b0, slice_position} >= ax_size) begin
              iss_meta.status = ST_POSITION;
            end else begin
              iss         = 1'b0;
              start_slice = 1'b1;
            end
          end
          CMD_SLICE: begin
            if ({1'b0, slice_axis} >= shape.dim_count) begin
              iss_meta.status = ST_AXIS;
            end else if ({1'b0, slice_position} >= ax_size) begin
              iss_meta.status = ST_POSITION;
            end else begin
              iss         = 1'b0;
              start_slice = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign mem_en    = iss_en;
  assign mem_we    = iss_we;
  assign mem_addr  = iss_addr;
  assign mem_wdata = write_value;

  // Sequencer and written-entry flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      written    <= '0;
      meta_valid <= 1'b0;
    end else begin
      meta_valid <= iss;
      if (iss_en && iss_we) begin
        written[iss_addr] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (start_slice) begin
            state <= S_SLICE;
          end
        end
        S_SLICE: begin
          if (iss && slice_last) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result fields and slice walk counters.
  always_ff @(posedge clk) begin
    meta <= iss_meta;
    if (start_slice) begin
      st    <= ax_st;
      block <= block_full[SIZE_W-1:0];
      base  <= base_full[SIZE_W-1:0];
      inner <= '0;
      count <= '0;
    end else if ((state == S_SLICE) && iss) begin
      count <= count + POS_W'(1);
      if (run_end) begin
        inner <= '0;
        base  <= run_next[SIZE_W-1:0];
      end else begin
        inner <= inner_inc[SIZE_W-1:0];
      end
    end
  end

endmodule

/* hw/rtl/stsr_outq.sv */
`timescale 1ns / 1ps

module stsr_outq (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  stsr_pkg::result_t push_data,
  output logic              out_valid,
  input  logic              out_stall,
  output stsr_pkg::result_t out_data,
  output logic [1:0]        level,
  output logic              pop
);

  import stsr_pkg::*;

  result_t    ent [2];
  logic       wr_ptr;
  logic       rd_ptr;

  assign out_valid = (level != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign out_data  = ent[rd_ptr];

  // Two-entry queue in front of the result channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      level  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   level <= level + 2'd1;
        2'b01:   level <= level - 2'd1;
        default: level <= level;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= push_data;
    end
  end

endmodule
